// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers. Each expects clk and rst in the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/snt_pkg.sv -----
package snt_pkg;

  localparam int SIGMOID_ENTRIES_DEF = 256;

  // Request kinds carried in s_axis_tuser.
  localparam logic [1:0] REQ_TRAIN  = 2'd0;
  localparam logic [1:0] REQ_INFER  = 2'd1;
  localparam logic [1:0] REQ_RELOAD = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEARN_RATE     = 2'd0;
  localparam logic [1:0] REG_START_WEIGHT_A = 2'd1;
  localparam logic [1:0] REG_START_WEIGHT_B = 2'd2;
  localparam logic [1:0] REG_START_OFFSET   = 2'd3;

  // Register reset values.
  localparam logic [15:0]        LEARN_RATE_RST = 16'd6554;
  localparam logic signed [31:0] START_RST      = 32'sd32768;

  // Q1.12 constants.
  localparam logic [12:0] ONE_Q12  = 13'd4096;
  localparam logic [12:0] HALF_Q12 = 13'd2048;

  localparam int MUL_A_W = 44;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 50;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_INDEX,
    S_LOOK,
    S_SLOPE,
    S_ERR,
    S_GRAD,
    S_RATE,
    S_MUL_FA,
    S_MUL_FB,
    S_UPD_B,
    S_DONE
  } state_t;

  // Add a small delta to a weight and clip to the signed 32-bit range.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                 input logic signed [32:0] d);
    logic signed [32:0] s;
    s = {w[31], w} + d;
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

// ----- hw/rtl/sigmoid_neuron_online_trainer_top.sv -----
// A train item runs every sequencer step, an infer item ends after the table
// lookup and a reload goes straight to the done step. The single shared 44x17
// multiplier takes one item at a time; a new beat is taken only when idle.
// A finished result waits in the output register while the next item runs.
// Reset (rst, synchronous, active high) loads the register defaults and sets
// all three weights to 0.5; the sigmoid table is constant and needs no fill.
`include "assert_macros.svh"

module sigmoid_neuron_online_trainer_top #(
  parameter int SIGMOID_ENTRIES = snt_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // feature_a[15:0], feature_b[31:16], goal[44:32], zero pad
  input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata   // probability[12:0], decision[13], weight_a_now[45:14],
                                      // weight_b_now[77:46], offset_now[109:78], zero pad
);

  localparam int IDX_W = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
  localparam int MA_W  = snt_pkg::MUL_A_W;
  localparam int MB_W  = snt_pkg::MUL_B_W;
  localparam int P_W   = snt_pkg::PROD_W;
  localparam int A_W   = snt_pkg::ACC_W;

  localparam logic signed [37:0] Z_MIN = -38'sd524288;
  localparam logic signed [37:0] Z_MAX = 38'sd524287;

  // Sigmoid table, built at elaboration. Entry k covers
  // zk = k*16/ENTRIES - 8 in Q16.16, floored to the LSB; e^|zk| comes from a Q32 Taylor series.
  typedef logic [12:0] rom_t [SIGMOID_ENTRIES];

  // Unsigned 64-bit quotient by shift and subtract, for the table build only.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t rom_init();
    rom_t        r;
    longint      zk;
    logic [63:0] mag;
    logic [63:0] term;
    logic [63:0] acc_e;
    logic [63:0] one;
    logic [63:0] den;
    logic [63:0] num;
    logic        stop;
    one = 64'd1 << 32;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      zk = longint'(udiv64(64'(k) << 20, 64'(SIGMOID_ENTRIES))) - 64'sd524288;
      mag = (zk < 0) ? 64'(-zk) : 64'(zk);
      term = one;
      acc_e = one;
      stop = 1'b0;
      for (int n = 1; n <= 64; n++) begin
        if (!stop) begin
          term = udiv64((term * mag) >> 16, 64'(n));
          if (term == 64'd0) begin
            stop = 1'b1;
          end else begin
            acc_e = acc_e + term;
          end
        end
      end
      den = acc_e + one;
      num = (zk >= 0) ? acc_e : one;
      r[k] = 13'(udiv64(num * 64'd4096 + (den >> 1), den));
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = rom_init();

  // configuration registers
  logic [15:0]        learn_rate;
  logic signed [31:0] start_weight_a;
  logic signed [31:0] start_weight_b;
  logic signed [31:0] start_offset;

  // live weights
  logic signed [31:0] weight_a;
  logic signed [31:0] weight_b;
  logic signed [31:0] offset;

  // item payload, held for the whole run
  logic [1:0]         req;
  logic signed [15:0] feat_a;
  logic signed [15:0] feat_b;
  logic [12:0]        goal;

  // working registers
  snt_pkg::state_t    state;
  snt_pkg::state_t    state_next;
  logic signed [A_W-1:0]  acc;
  logic signed [P_W-1:0]  prod;
  logic signed [25:0]     grad;
  logic signed [MA_W-1:0] gr;
  logic [12:0]            p;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic                   mul_en;

  logic               in_beat;
  logic               out_load;
  logic signed [37:0] z;
  logic [19:0]        z_off;
  logic signed [P_W-1:0]  prod_rnd12;
  logic signed [P_W-1:0]  prod_rnd36;
  logic signed [MA_W-1:0] gr_rnd24;
  logic signed [24:0]     delta_w;
  logic signed [19:0]     delta_o;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state == snt_pkg::S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // z = acc >> 12 with floor; clamp to [-8, 8) and offset by 8 (flip the sign bit).
  assign z = acc[A_W-1:12];
  always_comb begin
    priority if (z < Z_MIN) begin
      z_off = 20'd0;
    end else if (z > Z_MAX) begin
      z_off = 20'hFFFFF;
    end else begin
      z_off = z[19:0] ^ 20'h80000;
    end
  end

  // round half up: add half an LSB, keep the upper bits
  assign prod_rnd12 = prod + P_W'(64'sd2048);
  assign prod_rnd36 = prod + P_W'(64'sd34359738368);
  assign gr_rnd24   = gr + MA_W'(64'sd8388608);
  assign delta_w    = prod_rnd36[P_W-1:36];
  assign delta_o    = gr_rnd24[MA_W-1:24];

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      snt_pkg::S_IDLE: begin
        if (in_beat) begin
          state_next = (s_axis_tuser == snt_pkg::REQ_RELOAD) ? snt_pkg::S_DONE
                                                             : snt_pkg::S_MUL_A;
        end
      end
      snt_pkg::S_MUL_A:  state_next = snt_pkg::S_MUL_B;
      snt_pkg::S_MUL_B:  state_next = snt_pkg::S_SUM;
      snt_pkg::S_SUM:    state_next = snt_pkg::S_INDEX;
      snt_pkg::S_INDEX:  state_next = snt_pkg::S_LOOK;
      snt_pkg::S_LOOK: begin
        state_next = (req == snt_pkg::REQ_TRAIN) ? snt_pkg::S_SLOPE : snt_pkg::S_DONE;
      end
      snt_pkg::S_SLOPE:  state_next = snt_pkg::S_ERR;
      snt_pkg::S_ERR:    state_next = snt_pkg::S_GRAD;
      snt_pkg::S_GRAD:   state_next = snt_pkg::S_RATE;
      snt_pkg::S_RATE:   state_next = snt_pkg::S_MUL_FA;
      snt_pkg::S_MUL_FA: state_next = snt_pkg::S_MUL_FB;
      snt_pkg::S_MUL_FB: state_next = snt_pkg::S_UPD_B;
      snt_pkg::S_UPD_B:  state_next = snt_pkg::S_DONE;
      snt_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = snt_pkg::S_IDLE;
        end
      end
      default: state_next = snt_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: ready and multiplier operands.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_en        = 1'b1;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      snt_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        mul_en        = 1'b0;
      end
      snt_pkg::S_MUL_A: begin
        mul_a = MA_W'(weight_a);
        mul_b = MB_W'(feat_a);
      end
      snt_pkg::S_MUL_B: begin
        mul_a = MA_W'(weight_b);
        mul_b = MB_W'(feat_b);
      end
      snt_pkg::S_INDEX: begin
        mul_a = {{(MA_W - 20){1'b0}}, z_off};
        mul_b = MB_W'(SIGMOID_ENTRIES);
      end
      snt_pkg::S_SLOPE: begin
        // p * (1 - p)
        mul_a = {{(MA_W - 13){1'b0}}, p};
        mul_b = {4'b0, snt_pkg::ONE_Q12} - {4'b0, p};
      end
      snt_pkg::S_ERR: begin
        // (goal - p) * slope
        mul_a = prod[MA_W-1:0];
        mul_b = {4'b0, goal} - {4'b0, p};
      end
      snt_pkg::S_RATE: begin
        mul_a = MA_W'(grad);
        mul_b = {1'b0, learn_rate};
      end
      snt_pkg::S_MUL_FA: begin
        mul_a = prod[MA_W-1:0];
        mul_b = MB_W'(feat_a);
      end
      snt_pkg::S_MUL_FB: begin
        mul_a = gr;
        mul_b = MB_W'(feat_b);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate     <= snt_pkg::LEARN_RATE_RST;
      start_weight_a <= snt_pkg::START_RST;
      start_weight_b <= snt_pkg::START_RST;
      start_offset   <= snt_pkg::START_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        snt_pkg::REG_LEARN_RATE:     learn_rate     <= cfg_data[15:0];
        snt_pkg::REG_START_WEIGHT_A: start_weight_a <= cfg_data;
        snt_pkg::REG_START_WEIGHT_B: start_weight_b <= cfg_data;
        snt_pkg::REG_START_OFFSET:   start_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and live weights.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= snt_pkg::S_IDLE;
      weight_a <= snt_pkg::START_RST;
      weight_b <= snt_pkg::START_RST;
      offset   <= snt_pkg::START_RST;
    end else begin
      state <= state_next;
      if (in_beat && s_axis_tuser == snt_pkg::REQ_RELOAD) begin
        weight_a <= start_weight_a;
        weight_b <= start_weight_b;
        offset   <= start_offset;
      end
      if (state == snt_pkg::S_MUL_FB) begin
        weight_a <= snt_pkg::sat_add(weight_a, 33'(delta_w));
        offset   <= snt_pkg::sat_add(offset, 33'(delta_o));
      end
      if (state == snt_pkg::S_UPD_B) begin
        weight_b <= snt_pkg::sat_add(weight_b, 33'(delta_w));
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req    <= s_axis_tuser;
      feat_a <= s_axis_tdata[15:0];
      feat_b <= s_axis_tdata[31:16];
      goal   <= s_axis_tdata[44:32];
      // start the sum with offset in Q22.28
      acc    <= {{(A_W - 44){offset[31]}}, offset, 12'b0};
      p      <= 13'd0;
    end
    if (mul_en) begin
      prod <= mul_p;
    end
    if (state == snt_pkg::S_MUL_B || state == snt_pkg::S_SUM) begin
      acc <= acc + prod[A_W-1:0];
    end
    if (state == snt_pkg::S_LOOK) begin
      p <= SIG_ROM[prod[20 +: IDX_W]];
    end
    if (state == snt_pkg::S_GRAD) begin
      grad <= prod_rnd12[37:12];
    end
    if (state == snt_pkg::S_MUL_FA) begin
      gr <= prod[MA_W-1:0];
    end
  end

  // Output register: hold the finished beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {2'b0, offset, weight_b, weight_a, (p > snt_pkg::HALF_Q12), p};
    end
  end

  `ASSERT_NEXT(a_reload_restores, in_beat && s_axis_tuser == snt_pkg::REQ_RELOAD && !cfg_valid, weight_a == start_weight_a && weight_b == start_weight_b && offset == start_offset, "reload did not restore the start weights")
  `ASSERT_IMPL(a_index_in_range, state == snt_pkg::S_LOOK, prod[P_W-1:20] < (P_W - 20)'(SIGMOID_ENTRIES), "sigmoid index out of range")
  `ASSERT_IMPL(a_prob_bounded, state == snt_pkg::S_SLOPE, p <= snt_pkg::ONE_Q12, "probability above one")
  `ASSERT_NEXT(a_infer_keeps_weights, state == snt_pkg::S_LOOK && req != snt_pkg::REQ_TRAIN, $stable(weight_a) && $stable(weight_b) && $stable(offset), "infer item changed a weight")
  `ASSERT_IMPL(a_load_from_done, $rose(m_axis_tvalid), $past(state) == snt_pkg::S_DONE, "result beat raised outside the done step")

endmodule
